// File: sv/cbra_pkg.sv
// ----------------------------------------------------------------------------
// cbra_pkg
// Shared types and constants for the cyclic band rotate addresser.
// ----------------------------------------------------------------------------
package cbra_pkg;

    localparam int SIZE_W   = 9;    // size and shift registers
    localparam int MAPS_W   = 7;    // map count register
    localparam int IDX_W    = 30;   // element index width
    localparam int ADDR_W   = 5;    // apb byte address
    localparam int DATA_W   = 32;   // apb data
    localparam int S_DATA_W = 8;    // input stream data
    localparam int M_DATA_W = 64;   // output stream data
    localparam int XY_W     = 2 * SIZE_W;
    localparam int XYZ_W    = 3 * SIZE_W;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_SIZE_X    = 3'd0;
    localparam logic [2:0] REG_SIZE_Y    = 3'd1;
    localparam logic [2:0] REG_SIZE_Z    = 3'd2;
    localparam logic [2:0] REG_SHIFT_X   = 3'd3;
    localparam logic [2:0] REG_SHIFT_Y   = 3'd4;
    localparam logic [2:0] REG_SHIFT_Z   = 3'd5;
    localparam logic [2:0] REG_MAP_COUNT = 3'd6;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_LOAD,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3
    } cbra_state_t;

endpackage

// File: sv/cyclic_band_rotate_addresser.sv
// ----------------------------------------------------------------------------
// cyclic_band_rotate_addresser
// Source and destination element addresses for a cyclic 3-D rotation.
// ----------------------------------------------------------------------------
// accepted requests go to a two-entry output skid stage, the skid entry only on a stall
// throughput: one request per cycle while no recompute runs and the skid entry is empty
// every register write blocks requests while the rotated position is reduced
// one quotient bit a cycle and the offsets are multiplied
// reset is asynchronous: registers return to size 1, shift 0, one map,
// position and counters to zero, and the block is ready at once
module cyclic_band_rotate_addresser
    import cbra_pkg::*;
#(
    parameter int NUM_DIMS     = 3,
    parameter int MAX_DIM_SIZE = 256,
    parameter int MAX_MAPS     = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    // apb configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [0] restart, [7:1] zero
    // address stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // [29:0] source_index, [59:30] dest_index
    output logic                m_axis_tlast    // last_of_sample
);

    localparam int PW    = $clog2(MAX_DIM_SIZE);   // position within a dimension
    localparam int QW    = PW + 1;                 // position plus shift
    localparam int MW    = $clog2(MAX_MAPS + 1);
    localparam int KW    = $clog2(PW + 1);
    localparam int DW    = SIZE_W + PW;
    localparam int PAD_W = M_DATA_W - 2 * IDX_W;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                   input int dim);
        logic [SIZE_W-1:0] res;
        res = raw;
        if (dim >= NUM_DIMS || raw == '0)
            res = SIZE_W'(1);
        else if (int'(raw) > MAX_DIM_SIZE)
            res = SIZE_W'(MAX_DIM_SIZE);
        return res;
    endfunction

    // clamp to +/-(size-1), then bring a negative shift into range
    function automatic logic [SIZE_W-1:0] eff_shift(input logic [SIZE_W-1:0] raw,
                                                    input logic [SIZE_W-1:0] size);
        logic signed [SIZE_W+1:0] s;
        logic signed [SIZE_W+1:0] lim;
        s   = $signed({{2{raw[SIZE_W-1]}}, raw});
        lim = $signed({2'b00, size}) - (SIZE_W+2)'(1);
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        if (s < 0)
            s = s + $signed({2'b00, size});
        return s[SIZE_W-1:0];
    endfunction

    // configuration registers
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SIZE_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    logic [MAPS_W-1:0] map_count_reg;

    cbra_state_t state_reg, state_next;

    // destination position and counters
    logic [PW-1:0]    dst_x_reg, dst_x_next, dst_y_reg, dst_y_next, dst_z_reg, dst_z_next;
    logic [MW-1:0]    map_reg, map_next;
    logic [IDX_W-1:0] dest_reg, dest_next;

    // rotated position and partial source offsets
    logic [QW-1:0]    px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [XY_W-1:0]  row_reg, row_next, row0_reg, row0_next;
    logic [IDX_W-1:0] plane_reg, plane_next, plane0_reg, plane0_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [XY_W-1:0]  xy_reg, xy_next;
    logic [XYZ_W-1:0] xyz_reg, xyz_next;
    logic [KW-1:0]    k_reg, k_next;

    // output register and skid stage
    logic             out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [IDX_W-1:0] out_src_reg, out_src_next, out_dst_reg, out_dst_next;
    logic             skid_valid_reg, skid_valid_next, skid_last_reg, skid_last_next;
    logic [IDX_W-1:0] skid_src_reg, skid_src_next, skid_dst_reg, skid_dst_next;

    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic [SIZE_W-1:0] ex, ey, ez, sx, sy, sz;
    logic [MAPS_W-1:0] em;
    logic              accept, pop;

    // current item after an optional restart
    logic [PW-1:0]     dx_c, dy_c, dz_c;
    logic [MW-1:0]     mc_c;
    logic [IDX_W-1:0]  dc_c, plane_c, base_c, src_c;
    logic [QW-1:0]     px_c, py_c, pz_c;
    logic [XY_W-1:0]   row_c;
    logic              cx, cy, cz, cm, last_c;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= SIZE_W'(1);
            size_y_reg    <= SIZE_W'(1);
            size_z_reg    <= SIZE_W'(1);
            shift_x_reg   <= '0;
            shift_y_reg   <= '0;
            shift_z_reg   <= '0;
            map_count_reg <= MAPS_W'(1);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SIZE_X:    size_x_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg    <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg    <= pwdata[SIZE_W-1:0];
                REG_SHIFT_X:   shift_x_reg   <= pwdata[SIZE_W-1:0];
                REG_SHIFT_Y:   shift_y_reg   <= pwdata[SIZE_W-1:0];
                REG_SHIFT_Z:   shift_z_reg   <= pwdata[SIZE_W-1:0];
                REG_MAP_COUNT: map_count_reg <= pwdata[MAPS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SIZE_X:    prdata = DATA_W'(size_x_reg);
            REG_SIZE_Y:    prdata = DATA_W'(size_y_reg);
            REG_SIZE_Z:    prdata = DATA_W'(size_z_reg);
            REG_SHIFT_X:   prdata = DATA_W'(shift_x_reg);
            REG_SHIFT_Y:   prdata = DATA_W'(shift_y_reg);
            REG_SHIFT_Z:   prdata = DATA_W'(shift_z_reg);
            REG_MAP_COUNT: prdata = DATA_W'(map_count_reg);
            default:       prdata = '0;
        endcase
    end

    // effective extents and shifts
    always_comb
    begin
        ex = eff_size(size_x_reg, 0);
        ey = eff_size(size_y_reg, 1);
        ez = eff_size(size_z_reg, 2);
        sx = eff_shift(shift_x_reg, ex);
        sy = eff_shift(shift_y_reg, ey);
        sz = eff_shift(shift_z_reg, ez);
        if (map_count_reg == '0)
            em = MAPS_W'(1);
        else if (int'(map_count_reg) > MAX_MAPS)
            em = MAPS_W'(MAX_MAPS);
        else
            em = map_count_reg;
    end

    assign s_axis_tready = (state_reg == ST_RUN) && !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;

    // item datapath
    always_comb
    begin
        if (s_axis_tdata[0])
        begin
            dx_c    = '0;
            dy_c    = '0;
            dz_c    = '0;
            mc_c    = '0;
            dc_c    = '0;
            px_c    = QW'(sx);
            py_c    = QW'(sy);
            pz_c    = QW'(sz);
            row_c   = row0_reg;
            plane_c = plane0_reg;
            base_c  = '0;
        end
        else
        begin
            dx_c    = dst_x_reg;
            dy_c    = dst_y_reg;
            dz_c    = dst_z_reg;
            mc_c    = map_reg;
            dc_c    = dest_reg;
            px_c    = px_reg;
            py_c    = py_reg;
            pz_c    = pz_reg;
            row_c   = row_reg;
            plane_c = plane_reg;
            base_c  = base_reg;
        end
        src_c  = base_c + IDX_W'(px_c) + IDX_W'(row_c) + plane_c;
        cx     = 32'(dx_c) + 32'd1 >= 32'(ex);
        cy     = 32'(dy_c) + 32'd1 >= 32'(ey);
        cz     = 32'(dz_c) + 32'd1 >= 32'(ez);
        cm     = 32'(mc_c) + 32'd1 >= 32'(em);
        last_c = cx && cy && cz && cm;
    end

    // position update, recompute sequence after a register write
    always_comb
    begin
        state_next  = state_reg;
        dst_x_next  = dst_x_reg;
        dst_y_next  = dst_y_reg;
        dst_z_next  = dst_z_reg;
        map_next    = map_reg;
        dest_next   = dest_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;
        row_next    = row_reg;
        row0_next   = row0_reg;
        plane_next  = plane_reg;
        plane0_next = plane0_reg;
        base_next   = base_reg;
        xy_next     = xy_reg;
        xyz_next    = xyz_reg;
        k_next      = k_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    dst_x_next = dx_c;
                    dst_y_next = dy_c;
                    dst_z_next = dz_c;
                    map_next   = mc_c;
                    px_next    = px_c;
                    py_next    = py_c;
                    pz_next    = pz_c;
                    row_next   = row_c;
                    plane_next = plane_c;
                    base_next  = base_c;
                    if (last_c)
                    begin
                        dst_x_next = '0;
                        dst_y_next = '0;
                        dst_z_next = '0;
                        map_next   = '0;
                        dest_next  = '0;
                        px_next    = QW'(sx);
                        py_next    = QW'(sy);
                        pz_next    = QW'(sz);
                        row_next   = row0_reg;
                        plane_next = plane0_reg;
                        base_next  = '0;
                    end
                    else
                    begin
                        dest_next = dc_c + IDX_W'(1);
                        if (!cx)
                        begin
                            dst_x_next = dx_c + PW'(1);
                            px_next    = (32'(px_c) + 32'd1 == 32'(ex)) ? '0 : px_c + QW'(1);
                        end
                        else
                        begin
                            dst_x_next = '0;
                            px_next    = QW'(sx);
                            if (!cy)
                            begin
                                dst_y_next = dy_c + PW'(1);
                                if (32'(py_c) + 32'd1 == 32'(ey))
                                begin
                                    py_next  = '0;
                                    row_next = '0;
                                end
                                else
                                begin
                                    py_next  = py_c + QW'(1);
                                    row_next = row_c + XY_W'(ex);
                                end
                            end
                            else
                            begin
                                dst_y_next = '0;
                                py_next    = QW'(sy);
                                row_next   = row0_reg;
                                if (!cz)
                                begin
                                    dst_z_next = dz_c + PW'(1);
                                    if (32'(pz_c) + 32'd1 == 32'(ez))
                                    begin
                                        pz_next    = '0;
                                        plane_next = '0;
                                    end
                                    else
                                    begin
                                        pz_next    = pz_c + QW'(1);
                                        plane_next = plane_c + IDX_W'(xy_reg);
                                    end
                                end
                                else
                                begin
                                    dst_z_next = '0;
                                    pz_next    = QW'(sz);
                                    plane_next = plane0_reg;
                                    map_next   = mc_c + MW'(1);
                                    base_next  = base_c + IDX_W'(xyz_reg);
                                end
                            end
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                px_next    = QW'(dst_x_reg) + QW'(sx);
                py_next    = QW'(dst_y_reg) + QW'(sy);
                pz_next    = QW'(dst_z_reg) + QW'(sz);
                k_next     = KW'(PW);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // one restoring step per cycle, quotient discarded
                if (DW'(px_reg) >= (DW'(ex) << k_reg))
                    px_next = px_reg - QW'(DW'(ex) << k_reg);
                if (DW'(py_reg) >= (DW'(ey) << k_reg))
                    py_next = py_reg - QW'(DW'(ey) << k_reg);
                if (DW'(pz_reg) >= (DW'(ez) << k_reg))
                    pz_next = pz_reg - QW'(DW'(ez) << k_reg);
                k_next = k_reg - KW'(1);
                if (k_reg == '0)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                xy_next    = XY_W'(ex) * XY_W'(ey);
                row_next   = XY_W'(ex) * XY_W'(py_reg);
                row0_next  = XY_W'(ex) * XY_W'(sy);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                xyz_next    = XYZ_W'(xy_reg) * XYZ_W'(ez);
                plane_next  = IDX_W'(xy_reg) * IDX_W'(pz_reg);
                plane0_next = IDX_W'(xy_reg) * IDX_W'(sz);
                state_next  = ST_MUL3;
            end
            ST_MUL3:
            begin
                base_next  = IDX_W'(map_reg) * IDX_W'(xyz_reg);
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cfg_wr)
            state_next = ST_LOAD;
    end

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_src_next    = out_src_reg;
        out_dst_next    = out_dst_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_src_next   = skid_src_reg;
        skid_dst_next   = skid_dst_reg;
        skid_last_next  = skid_last_reg;
        if (pop && skid_valid_reg)
        begin
            out_src_next    = skid_src_reg;
            out_dst_next    = skid_dst_reg;
            out_last_next   = skid_last_reg;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_next = 1'b1;
                skid_src_next   = src_c;
                skid_dst_next   = dc_c;
                skid_last_next  = last_c;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_src_next   = src_c;
                out_dst_next   = dc_c;
                out_last_next  = last_c;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            dst_x_reg      <= '0;
            dst_y_reg      <= '0;
            dst_z_reg      <= '0;
            map_reg        <= '0;
            dest_reg       <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            pz_reg         <= '0;
            row_reg        <= '0;
            row0_reg       <= '0;
            plane_reg      <= '0;
            plane0_reg     <= '0;
            base_reg       <= '0;
            xy_reg         <= XY_W'(1);
            xyz_reg        <= XYZ_W'(1);
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dst_x_reg      <= dst_x_next;
            dst_y_reg      <= dst_y_next;
            dst_z_reg      <= dst_z_next;
            map_reg        <= map_next;
            dest_reg       <= dest_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            pz_reg         <= pz_next;
            row_reg        <= row_next;
            row0_reg       <= row0_next;
            plane_reg      <= plane_next;
            plane0_reg     <= plane0_next;
            base_reg       <= base_next;
            xy_reg         <= xy_next;
            xyz_reg        <= xyz_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_src_reg   <= out_src_next;
        out_dst_reg   <= out_dst_next;
        out_last_reg  <= out_last_next;
        skid_src_reg  <= skid_src_next;
        skid_dst_reg  <= skid_dst_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_dst_reg, out_src_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: sv/cbra_checker.sv
// ----------------------------------------------------------------------------
// cbra_checker
// Port-level checks for the cyclic band rotate addresser, bound to the top.
// ----------------------------------------------------------------------------
module cbra_checker
    import cbra_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic                pready,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // a stalled address stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("address dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("address changed while stalled");

    // a register write starts the recompute, which blocks requests
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=> !s_axis_tready)
        else $error("request taken right after a register write");

    // an accepted request reaches an empty output register in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("accepted request gave no address next cycle");

endmodule

bind cyclic_band_rotate_addresser cbra_checker u_cbra_checker (.*);

// File: tb/sv/tb_cyclic_band_rotate_addresser.sv
// ----------------------------------------------------------------------------
// tb_cyclic_band_rotate_addresser
// Sends restart and advance requests, programs the size, shift and map count
// registers between runs, predicts source index, destination index and end of
// sample for every accepted request and checks them against the address stream.
// ----------------------------------------------------------------------------
module tb_cyclic_band_rotate_addresser;
    import cbra_pkg::*;

    localparam int NUM_DIMS     = 3;
    localparam int MAX_DIM_SIZE = 256;
    localparam int MAX_MAPS     = 64;
    localparam int RAND_REQS    = 1650;

    // no register behind this index, writes must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic             last;
    } addr_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // [0] restart, [7:1] zero
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;         // [29:0] source_index, [59:30] dest_index
    logic                m_axis_tlast;         // last_of_sample

    logic   restart_q [$];  // requests not yet presented
    addr_t  addr_q [$];     // predicted addresses, oldest first
    addr_t  got_addr;
    addr_t  want_addr;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned mismatch_cnt   = 0;

    // register copies and walk position of the predictor
    logic [SIZE_W-1:0] cfg_size_x  = 9'd1;
    logic [SIZE_W-1:0] cfg_size_y  = 9'd1;
    logic [SIZE_W-1:0] cfg_size_z  = 9'd1;
    logic [SIZE_W-1:0] cfg_shift_x = '0;
    logic [SIZE_W-1:0] cfg_shift_y = '0;
    logic [SIZE_W-1:0] cfg_shift_z = '0;
    logic [MAPS_W-1:0] cfg_maps    = 7'd1;
    logic [7:0]        pos_x       = '0;
    logic [7:0]        pos_y       = '0;
    logic [7:0]        pos_z       = '0;
    logic [5:0]        pos_map     = '0;
    logic [IDX_W-1:0]  dest_cnt    = '0;

    cyclic_band_rotate_addresser #(
        .NUM_DIMS     (NUM_DIMS),
        .MAX_DIM_SIZE (MAX_DIM_SIZE),
        .MAX_MAPS     (MAX_MAPS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned extent(input logic [SIZE_W-1:0] raw, input int dim);
        if (dim >= NUM_DIMS || raw == 0)
            return 1;
        if (raw > MAX_DIM_SIZE)
            return MAX_DIM_SIZE;
        return raw;
    endfunction

    // clamp to +-(size-1), then fold a negative amount into 0..size-1
    function automatic int unsigned rot_amount(input logic [SIZE_W-1:0] raw,
                                               input int unsigned size, input int dim);
        int s;
        int lim;
        if (dim >= NUM_DIMS)
            return 0;
        s   = $signed(raw);
        lim = size - 1;
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        if (s < 0)
            s = s + int'(size);
        return s;
    endfunction

    function automatic addr_t rotate_step(input logic restart);
        int unsigned ex, ey, ez, em;
        int unsigned sx, sy, sz;
        int unsigned px, py, pz, src;
        logic        wx, wy, wz, wm;
        addr_t       r;
        ex = extent(cfg_size_x, 0);
        ey = extent(cfg_size_y, 1);
        ez = extent(cfg_size_z, 2);
        em = (cfg_maps == 0) ? 1 : ((cfg_maps > MAX_MAPS) ? MAX_MAPS : cfg_maps);
        sx = rot_amount(cfg_shift_x, ex, 0);
        sy = rot_amount(cfg_shift_y, ey, 1);
        sz = rot_amount(cfg_shift_z, ez, 2);
        if (restart)
        begin
            pos_x    = '0;
            pos_y    = '0;
            pos_z    = '0;
            pos_map  = '0;
            dest_cnt = '0;
        end
        // a position left over from a larger extent is folded here
        px  = (pos_x + sx) % ex;
        py  = (pos_y + sy) % ey;
        pz  = (pos_z + sz) % ez;
        src = pos_map * ex * ey * ez + px + ex * (py + ey * pz);
        wx  = (pos_x + 1 >= ex);
        wy  = (pos_y + 1 >= ey);
        wz  = (pos_z + 1 >= ez);
        wm  = (pos_map + 1 >= em);
        r.src  = src[IDX_W-1:0];
        r.dst  = dest_cnt;
        r.last = wx && wy && wz && wm;
        if (r.last)
        begin
            pos_x    = '0;
            pos_y    = '0;
            pos_z    = '0;
            pos_map  = '0;
            dest_cnt = '0;
        end
        else
        begin
            dest_cnt = dest_cnt + 1'b1;
            if (!wx)
                pos_x = pos_x + 1'b1;
            else
            begin
                pos_x = '0;
                if (!wy)
                    pos_y = pos_y + 1'b1;
                else
                begin
                    pos_y = '0;
                    if (!wz)
                        pos_z = pos_z + 1'b1;
                    else
                    begin
                        pos_z   = '0;
                        pos_map = pos_map + 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // append one request at the tail of the pending queue
    task automatic queue_req(input logic restart);
        restart_q.insert(restart_q.size(), restart);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (restart_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(S_DATA_W-1){1'b0}}, restart_q.pop_front()};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            addr_q.insert(addr_q.size(), rotate_step(s_axis_tdata[0]));
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // address monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_addr.src  = m_axis_tdata[IDX_W-1:0];
            got_addr.dst  = m_axis_tdata[2*IDX_W-1:IDX_W];
            got_addr.last = m_axis_tlast;
            if (addr_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected address: src %0d dst %0d last %0b",
                             got_addr.src, got_addr.dst, got_addr.last);
            end
            else
            begin
                want_addr = addr_q.pop_front();
                if (got_addr.src !== want_addr.src || got_addr.dst !== want_addr.dst ||
                    got_addr.last !== want_addr.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp/got: src %0d/%0d dst %0d/%0d last %0b/%0b",
                                 want_addr.src, got_addr.src, want_addr.dst, got_addr.dst,
                                 want_addr.last, got_addr.last);
                end
            end
        end
    end

    // returns once every request has been presented and every address is back
    task automatic wait_drained();
        @(negedge clk);
        while (restart_q.size() != 0 || s_axis_tvalid || addr_q.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE_X:    cfg_size_x  = val[SIZE_W-1:0];
            REG_SIZE_Y:    cfg_size_y  = val[SIZE_W-1:0];
            REG_SIZE_Z:    cfg_size_z  = val[SIZE_W-1:0];
            REG_SHIFT_X:   cfg_shift_x = val[SIZE_W-1:0];
            REG_SHIFT_Y:   cfg_shift_y = val[SIZE_W-1:0];
            REG_SHIFT_Z:   cfg_shift_z = val[SIZE_W-1:0];
            REG_MAP_COUNT: cfg_maps    = val[MAPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] sx, sy, sz, hx, hy, hz, maps);
        wait_drained();
        reg_write(REG_SIZE_X, sx);
        reg_write(REG_SIZE_Y, sy);
        reg_write(REG_SIZE_Z, sz);
        reg_write(REG_SHIFT_X, hx);
        reg_write(REG_SHIFT_Y, hy);
        reg_write(REG_SHIFT_Z, hz);
        reg_write(REG_MAP_COUNT, maps);
    endtask

    function automatic logic [31:0] rand_size(input int unsigned small_max);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(5))
                0:       return 0;
                1:       return 1;
                2:       return 255;
                3:       return 256;
                4:       return 257;
                default: return 511;
            endcase
        end
        return $urandom_range(1, small_max);
    endfunction

    // mostly in range, sign extended; sometimes any 9-bit pattern
    function automatic logic [31:0] rand_shift(input logic [31:0] raw_size);
        int unsigned lim;
        int          s;
        logic [8:0]  v;
        lim = extent(raw_size[SIZE_W-1:0], 0) - 1;
        if ($urandom_range(3) == 0)
        begin
            v = $urandom_range(511);
            return {{23{v[8]}}, v};
        end
        s = int'($urandom_range(2 * lim)) - int'(lim);
        return s;
    endfunction

    function automatic logic [31:0] rand_maps();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(5))
                0:       return 0;
                1:       return 1;
                2:       return 63;
                3:       return 64;
                4:       return 65;
                default: return 127;
            endcase
        end
        return $urandom_range(1, 3);
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned set_no;
        int unsigned n;
        logic [31:0] vx, vy, vz;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: every request is a whole one-element sample
        queue_req(1'b0);
        queue_req(1'b1);

        // 2x2x2 with two maps, shifts beyond range and the most negative shift
        program_regs(2, 2, 2, 32'h0000_00FF, 32'hFFFF_FFFF, 32'h0000_0100, 2);
        queue_req(1'b1);
        repeat (16) queue_req(1'b0);

        // oversized and zero extents, oversized map count, changed mid-sample
        program_regs(511, 0, 256, 32'h0000_00FF, 32'hFFFF_FF01, 0, 127);
        queue_req(1'b0);
        queue_req(1'b1);
        queue_req(1'b0);

        wait_drained();
        reg_write(REG_UNUSED, 32'h0000_01FF);
        reg_write(REG_MAP_COUNT, 0);
        queue_req(1'b0);
        queue_req(1'b0);

        sent   = 0;
        set_no = 0;
        while (sent < RAND_REQS)
        begin
            vx = rand_size(6);
            vy = rand_size(4);
            vz = rand_size(3);
            program_regs(vx, vy, vz, rand_shift(vx), rand_shift(vy), rand_shift(vz),
                         rand_maps());
            case (set_no % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 77;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 77;
                end
                default:
                begin
                    src_idle_pct   = 21;
                    sink_stall_pct = 21;
                end
            endcase
            n = $urandom_range(40, 110);
            for (int i = 0; i < n; i++)
            begin
                // hold the sender until every address has come back
                if (set_no % 3 == 0 && i == n / 2)
                    wait_drained();
                if (i == 0)
                    queue_req($urandom_range(3) != 0);
                else
                    queue_req($urandom_range(99) < 3);
            end
            sent += n;
            set_no++;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[cyclic_band_rotate_addresser] OK");
        else
            $display("[cyclic_band_rotate_addresser] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[cyclic_band_rotate_addresser] ERROR");
        $finish;
    end

endmodule
